@@ src/assert_macros.svh @@
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define PCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pcm assertion failed");

// next-cycle implication, off while in reset
`define PCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pcm assertion failed");

`endif

@@ src/pcm_pkg.sv @@
package pcm_pkg;

	localparam int PALETTE_DEPTH = 64;
	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam int SIZE_W = 7;
	localparam int DIST_W = 18;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [SIZE_W-1:0] PALETTE_SIZE_RESET = 7'd61;

	typedef enum logic {
		CMD_MAP   = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_PALETTE_SIZE = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// item travelling down the cell chain with its running best match
	typedef struct packed {
		logic              command;
		rgb_t              pix;
		logic [IDX_W-1:0]  entry_index;
		logic              frame_start;
		logic [DIST_W-1:0] best_dist;
		logic [IDX_W-1:0]  best_idx;
		rgb_t              best_rgb;
	} tok_t;

	function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return 16'(d) * 16'(d);
	endfunction

endpackage

@@ src/pcm_if.sv @@
interface pcm_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [5:0] entry_index;
	logic       frame_start;

	modport source (output valid, output command, output red, output green, output blue,
		output entry_index, output frame_start, input ready);
	modport sink (input valid, input command, input red, input green, input blue,
		input entry_index, input frame_start, output ready);
endinterface

interface pcm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] mapped_red;
	logic [7:0] mapped_green;
	logic [7:0] mapped_blue;
	logic [5:0] palette_index;
	logic       first_seen;

	modport source (output valid, output mapped_red, output mapped_green, output mapped_blue,
		output palette_index, output first_seen, input ready);
	modport sink (input valid, input mapped_red, input mapped_green, input mapped_blue,
		input palette_index, input first_seen, output ready);
endinterface

@@ src/pcm_cell.sv @@
module pcm_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [pcm_pkg::IDX_W-1:0]   cell_idx,
	input  logic [pcm_pkg::SIZE_W-1:0]  palette_size,
	input  logic                        up_valid,
	input  pcm_pkg::tok_t               up_tok,
	output logic                        dn_valid,
	output pcm_pkg::tok_t               dn_tok
);

	pcm_pkg::rgb_t                     entry_q;
	logic                              valid_s1;
	pcm_pkg::tok_t                     tok_s1;
	logic                              act_s1;
	logic [pcm_pkg::DIST_W-1:0]        dist_s1;
	pcm_pkg::rgb_t                     cand_s1;
	logic                              valid_s2;
	pcm_pkg::tok_t                     tok_s2;

	logic                              wr_hit;
	logic                              act_d;
	logic [pcm_pkg::DIST_W-1:0]        dist_d;
	logic                              upd;
	pcm_pkg::tok_t                     tok_nxt;

	// a load command drops its color in the cell it names
	assign wr_hit = adv && up_valid && (up_tok.command == pcm_pkg::CMD_WRITE)
		&& (up_tok.entry_index == cell_idx);

	// entry zero is always searched, the rest only below palette_size
	assign act_d = (cell_idx == '0)
		|| (pcm_pkg::SIZE_W'(cell_idx) < palette_size);

	assign dist_d = pcm_pkg::DIST_W'(pcm_pkg::sq_diff(up_tok.pix.red, entry_q.red))
		+ pcm_pkg::DIST_W'(pcm_pkg::sq_diff(up_tok.pix.green, entry_q.green))
		+ pcm_pkg::DIST_W'(pcm_pkg::sq_diff(up_tok.pix.blue, entry_q.blue));

	// strict less keeps the lower index on a tie
	always_comb begin
		upd = valid_s1 && (tok_s1.command == pcm_pkg::CMD_MAP) && act_s1
			&& (dist_s1 < tok_s1.best_dist);
		tok_nxt = tok_s1;
		if (upd) begin
			tok_nxt.best_dist = dist_s1;
			tok_nxt.best_idx  = cell_idx;
			tok_nxt.best_rgb  = cand_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			entry_q <= up_tok.pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1  <= up_tok;
			act_s1  <= act_d;
			dist_s1 <= dist_d;
			cand_s1 <= entry_q;
			tok_s2  <= tok_nxt;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_tok   = tok_s2;

endmodule

@@ src/pcm_seen.sv @@
`include "assert_macros.svh"

module pcm_seen (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	input  pcm_pkg::tok_t     tok,
	output logic              adv,
	pcm_out_if.source         pix_out
);

	logic [pcm_pkg::PALETTE_DEPTH-1:0] seen_q;
	logic                              out_valid_q;
	pcm_pkg::rgb_t                     out_rgb_q;
	logic [pcm_pkg::IDX_W-1:0]         out_idx_q;
	logic                              out_first_q;

	logic                              is_map;
	logic [pcm_pkg::PALETTE_DEPTH-1:0] seen_base;
	logic [pcm_pkg::PALETTE_DEPTH-1:0] seen_bit;
	logic                              first;

	assign adv    = !out_valid_q || pix_out.ready;
	assign is_map = tok_valid && (tok.command == pcm_pkg::CMD_MAP);

	// frame start wipes the marks before this pixel is looked up
	always_comb begin
		seen_base = tok.frame_start ? '0 : seen_q;
		seen_bit  = '0;
		seen_bit[tok.best_idx] = 1'b1;
		first     = !seen_base[tok.best_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= is_map;
			if (is_map) begin
				seen_q <= seen_base | seen_bit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_map) begin
			out_rgb_q   <= tok.best_rgb;
			out_idx_q   <= tok.best_idx;
			out_first_q <= first;
		end
	end

	assign pix_out.valid         = out_valid_q;
	assign pix_out.mapped_red    = out_rgb_q.red;
	assign pix_out.mapped_green  = out_rgb_q.green;
	assign pix_out.mapped_blue   = out_rgb_q.blue;
	assign pix_out.palette_index = out_idx_q;
	assign pix_out.first_seen    = out_first_q;

	`PCM_ASSERT_NXT(a_frame_start_first, clk, arst_n, adv && is_map && tok.frame_start, out_valid_q && out_first_q)
	`PCM_ASSERT_NXT(a_mark_set, clk, arst_n, adv && is_map, seen_q[out_idx_q])
	`PCM_ASSERT_NXT(a_load_silent, clk, arst_n, adv && !is_map, !out_valid_q)
	`PCM_ASSERT_NXT(a_marks_hold, clk, arst_n, !(adv && is_map), $stable(seen_q))

endmodule

@@ src/nearest_palette_color_mapper_unit.sv @@
// nearest palette color mapper
// pix_in carries commands: a load writes red/green/blue into palette slot
// entry_index, a map searches slot 0 and every slot below palette_size for
// the color with the smallest squared rgb distance (lowest index on ties)
// pix_out carries one result per map: the chosen color, its index and a
// first_seen flag for the first hit of that index since the last map with frame_start
// apb register 0 at address 0 is palette_size (7 bits, reset 61)
// every item walks a chain of 64 cells, one per palette slot, two register
// stages per cell, then one output register; one item is taken per cycle
// while it does not stall; the chain moves as a whole and stalls only
// while the output register holds a result that pix_out does not take,
// and pix_in.ready drops with it
// reset clears the chain, the seen marks and the output valid, and sets
// palette_size to 61; palette slots hold garbage until loaded
module nearest_palette_color_mapper_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pcm_pkg::ADDR_W-1:0]  paddr,
	input  logic [pcm_pkg::DATA_W-1:0]  pwdata,
	output logic [pcm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	pcm_in_if.sink                      pix_in,
	pcm_out_if.source                   pix_out
);

	logic [pcm_pkg::SIZE_W-1:0] palette_size_q;
	logic                       adv;
	logic                       reg_sel;
	pcm_pkg::tok_t              in_tok;

	// chain taps: slot 0 is the input side, last slot feeds the output stage
	logic          chain_vld [pcm_pkg::PALETTE_DEPTH+1];
	pcm_pkg::tok_t chain_tok [pcm_pkg::PALETTE_DEPTH+1];

	// apb: no wait states, register chosen by the word address
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == pcm_pkg::REG_PALETTE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= pcm_pkg::PALETTE_SIZE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			palette_size_q <= pwdata[pcm_pkg::SIZE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = pcm_pkg::DATA_W'(palette_size_q);
		end
	end

	// inputs enter the chain with a best distance above any real one
	assign pix_in.ready = adv;
	assign chain_vld[0] = pix_in.valid;
	assign chain_tok[0] = in_tok;

	always_comb begin
		in_tok              = '0;
		in_tok.command      = pix_in.command;
		in_tok.pix.red      = pix_in.red;
		in_tok.pix.green    = pix_in.green;
		in_tok.pix.blue     = pix_in.blue;
		in_tok.entry_index  = pix_in.entry_index;
		in_tok.frame_start  = pix_in.frame_start;
		in_tok.best_dist    = '1;
	end

	// one cell per palette slot
	for (genvar i = 0; i < pcm_pkg::PALETTE_DEPTH; i++) begin : g_cell
		pcm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.adv          (adv),
			.cell_idx     (pcm_pkg::IDX_W'(i)),
			.palette_size (palette_size_q),
			.up_valid     (chain_vld[i]),
			.up_tok       (chain_tok[i]),
			.dn_valid     (chain_vld[i+1]),
			.dn_tok       (chain_tok[i+1])
		);
	end

	// seen marks and the output register
	pcm_seen u_seen (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (chain_vld[pcm_pkg::PALETTE_DEPTH]),
		.tok       (chain_tok[pcm_pkg::PALETTE_DEPTH]),
		.adv       (adv),
		.pix_out   (pix_out)
	);

endmodule

@@ verif/tb_nearest_palette_color_mapper_unit.sv @@
module tb_nearest_palette_color_mapper_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// time for a map result to come through the whole chain, with a little slack on top
	localparam int SETTLE_CYCLES = 140;
	// cycles without any transfer before the run is declared hung
	localparam int QUIET_LIMIT = 4000;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_ITEMS = 110;
	// phase in which the output side holds off long enough to back up the whole chain
	localparam int LONG_HOLD_PHASE = 2;
	localparam int LONG_HOLD_CYCLES = 400;
	// phase in which the input side stops halfway until every map result is back
	localparam int PAUSE_PHASE = 4;
	localparam int PRINT_LIMIT = 50;
	localparam logic [pcm_pkg::ADDR_W-1:0] SIZE_REG_ADDR =
		pcm_pkg::ADDR_W'(4 * int'(pcm_pkg::REG_PALETTE_SIZE));

	// palette_size per random phase: small, full depth, the single-entry extreme,
	// an oversized value that saturates, and a zero that falls back to one entry
	localparam int PHASE_SIZES [NUM_PHASES] = '{8, 64, 1, 127, 0, 61, 2, 64, 37, 16};

	typedef struct packed {
		pcm_pkg::cmd_t             command;
		pcm_pkg::rgb_t             color;
		logic [pcm_pkg::IDX_W-1:0] entry_index;
		logic                      frame_start;
	} pixel_cmd_t;

	typedef struct packed {
		pcm_pkg::rgb_t             color;
		logic [pcm_pkg::IDX_W-1:0] palette_index;
		logic                      first_seen;
	} mapped_pixel_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_SIZE
	} row_kind_t;

	// one line of the directed sequence: either a palette_size write or one command,
	// with the result typed in where it is obvious
	typedef struct packed {
		row_kind_t                  kind;
		logic [pcm_pkg::SIZE_W-1:0] size_val;
		pcm_pkg::cmd_t              command;
		logic [7:0]                 red;
		logic [7:0]                 green;
		logic [7:0]                 blue;
		logic [pcm_pkg::IDX_W-1:0]  entry_index;
		logic                       frame_start;
		logic                       checked;
		logic [7:0]                 exp_red;
		logic [7:0]                 exp_green;
		logic [7:0]                 exp_blue;
		logic [pcm_pkg::IDX_W-1:0]  exp_index;
		logic                       exp_first;
	} dir_row_t;

	localparam int DIR_ROWS = 21;

	// palette used here: 0 black, 1 white, 2 red, 3 blue
	dir_row_t dir_table [DIR_ROWS] = '{
		// search only the four loaded slots
		'{ROW_SIZE, 7'd4, pcm_pkg::CMD_MAP, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_WRITE, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_WRITE, 8'd255, 8'd255, 8'd255, 6'd1, 1'b0,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_WRITE, 8'd255, 8'd0, 8'd0, 6'd2, 1'b0,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_WRITE, 8'd0, 8'd0, 8'd255, 6'd3, 1'b0,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		// exact hits on the extremes, first and repeated
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd0, 8'd0, 8'd0, 6'd0, 1'b1,
			1'b1, 8'd0, 8'd0, 8'd0, 6'd0, 1'b1},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd255, 8'd255, 8'd255, 6'd0, 1'b0,
			1'b1, 8'd255, 8'd255, 8'd255, 6'd1, 1'b1},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0,
			1'b1, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		// equally far from red and blue: the lower slot wins
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd128, 8'd0, 8'd128, 6'd0, 1'b0,
			1'b1, 8'd255, 8'd0, 8'd0, 6'd2, 1'b1},
		// new frame: black counts as first again
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd10, 8'd10, 8'd10, 6'd0, 1'b1,
			1'b1, 8'd0, 8'd0, 8'd0, 6'd0, 1'b1},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd250, 8'd5, 8'd5, 6'd0, 1'b0,
			1'b1, 8'd255, 8'd0, 8'd0, 6'd2, 1'b1},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd0, 8'd0, 8'd255, 6'd63, 1'b0,
			1'b1, 8'd0, 8'd0, 8'd255, 6'd3, 1'b1},
		// frame_start on a load must not clear the seen marks
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_WRITE, 8'd0, 8'd0, 8'd255, 6'd3, 1'b1,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd0, 8'd0, 8'd250, 6'd0, 1'b0,
			1'b1, 8'd0, 8'd0, 8'd255, 6'd3, 1'b0},
		// size zero searches slot 0 only
		'{ROW_SIZE, 7'd0, pcm_pkg::CMD_MAP, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd255, 8'd255, 8'd255, 6'd0, 1'b0,
			1'b1, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		'{ROW_SIZE, 7'd1, pcm_pkg::CMD_MAP, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd200, 8'd100, 8'd50, 6'd0, 1'b1,
			1'b1, 8'd0, 8'd0, 8'd0, 6'd0, 1'b1},
		'{ROW_SIZE, 7'd4, pcm_pkg::CMD_MAP, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		// white and red tie here; left to the predictor
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_MAP, 8'd255, 8'd255, 8'd0, 6'd0, 1'b0,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0},
		// top slot load, outside the searched range for now
		'{ROW_ITEM, 7'd0, pcm_pkg::CMD_WRITE, 8'd1, 8'd2, 8'd3, 6'd63, 1'b0,
			1'b0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [pcm_pkg::ADDR_W-1:0] paddr;
	logic [pcm_pkg::DATA_W-1:0] pwdata;
	logic [pcm_pkg::DATA_W-1:0] prdata;
	logic pready;

	pcm_in_if  pix_in ();
	pcm_out_if pix_out ();

	nearest_palette_color_mapper_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	// predictor state: palette contents, which slots were ever loaded, seen marks, size
	pcm_pkg::rgb_t              pal_model [pcm_pkg::PALETTE_DEPTH];
	bit                         pal_loaded [pcm_pkg::PALETTE_DEPTH];
	bit                         seen_model [pcm_pkg::PALETTE_DEPTH];
	logic [pcm_pkg::SIZE_W-1:0] size_model;

	// map results still owed by the block, oldest first
	mapped_pixel_t expected_maps [$];

	int  mismatch_count = 0;
	int  maps_checked = 0;
	int  loads_sent = 0;
	int  size_settings = 0;
	int  quiet_cycles = 0;
	int  hold_request = 0;
	bit  src_idle_on = 1'b1;
	bit  sink_idle_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t ns: error: %s", $time, msg);
	endtask

	// slots actually searched for a given palette_size
	function automatic int search_len(input logic [pcm_pkg::SIZE_W-1:0] sz);
		if (sz == 0)
			return 1;
		if (int'(sz) > pcm_pkg::PALETTE_DEPTH)
			return pcm_pkg::PALETTE_DEPTH;
		return int'(sz);
	endfunction

	// applies one command to the predictor state; returns 1 when a map result follows
	function automatic bit predict_nearest(input pixel_cmd_t it, output mapped_pixel_t res);
		int n;
		int best;
		int best_dist;
		int d;
		int dr;
		int dg;
		int db;
		res = '0;
		if (it.command == pcm_pkg::CMD_WRITE) begin
			if (int'(it.entry_index) < pcm_pkg::PALETTE_DEPTH) begin
				pal_model[it.entry_index] = it.color;
				pal_loaded[it.entry_index] = 1'b1;
			end
			return 1'b0;
		end
		if (it.frame_start) begin
			foreach (seen_model[i])
				seen_model[i] = 1'b0;
		end
		n = search_len(size_model);
		best = 0;
		best_dist = 0;
		for (int i = 0; i < n; i++) begin
			dr = int'(pal_model[i].red) - int'(it.color.red);
			dg = int'(pal_model[i].green) - int'(it.color.green);
			db = int'(pal_model[i].blue) - int'(it.color.blue);
			d = dr * dr + dg * dg + db * db;
			// strict less keeps the lowest slot on a tie
			if (i == 0 || d < best_dist) begin
				best_dist = d;
				best = i;
			end
		end
		res.color = pal_model[best];
		res.palette_index = pcm_pkg::IDX_W'(best);
		res.first_seen = !seen_model[best];
		seen_model[best] = 1'b1;
		return 1'b1;
	endfunction

	// moves a color component by a few steps, clamped to the 8-bit range
	function automatic logic [7:0] nudge(input logic [7:0] v);
		int t;
		t = int'(v) + int'($urandom_range(0, 6)) - 3;
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return 8'(t);
	endfunction

	// offers one command, optionally after an idle burst, and records what it should produce
	task automatic send_cmd(input pixel_cmd_t it, input bit typed, input mapped_pixel_t typed_res);
		mapped_pixel_t predicted;
		if (src_idle_on && $urandom_range(0, 7) == 0) begin
			pix_in.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.command <= it.command;
		pix_in.red <= it.color.red;
		pix_in.green <= it.color.green;
		pix_in.blue <= it.color.blue;
		pix_in.entry_index <= it.entry_index;
		pix_in.frame_start <= it.frame_start;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		if (predict_nearest(it, predicted))
			expected_maps.insert(expected_maps.size(), typed ? typed_res : predicted);
		else
			loads_sent++;
	endtask

	// register writes only with the chain empty: results back and loads flushed
	task automatic set_palette_size(input logic [pcm_pkg::SIZE_W-1:0] sz);
		pix_in.valid <= 1'b0;
		while (expected_maps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SIZE_REG_ADDR;
		pwdata <= pcm_pkg::DATA_W'(sz);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_model = sz;
		size_settings++;
	endtask

	// output side: random stall bursts, plus a long hold when asked for
	initial begin
		int burst_left;
		int hold_left;
		burst_left = 0;
		hold_left = 0;
		pix_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				pix_out.ready <= 1'b0;
			end else if (burst_left != 0) begin
				burst_left--;
				pix_out.ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(1, 14) - 1;
				pix_out.ready <= 1'b0;
			end else begin
				pix_out.ready <= 1'b1;
			end
		end
	end

	// result checker: every output transfer against the oldest expectation
	always @(posedge clk) begin
		mapped_pixel_t want;
		if (arst_n && pix_out.valid && pix_out.ready) begin
			if (expected_maps.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, index %0d",
					pix_out.palette_index));
			end else begin
				want = expected_maps.pop_front();
				maps_checked++;
				if (pix_out.mapped_red !== want.color.red)
					report_mismatch($sformatf("mapped_red got %0d want %0d",
						pix_out.mapped_red, want.color.red));
				if (pix_out.mapped_green !== want.color.green)
					report_mismatch($sformatf("mapped_green got %0d want %0d",
						pix_out.mapped_green, want.color.green));
				if (pix_out.mapped_blue !== want.color.blue)
					report_mismatch($sformatf("mapped_blue got %0d want %0d",
						pix_out.mapped_blue, want.color.blue));
				if (pix_out.palette_index !== want.palette_index)
					report_mismatch($sformatf("palette_index got %0d want %0d",
						pix_out.palette_index, want.palette_index));
				if (pix_out.first_seen !== want.first_seen)
					report_mismatch($sformatf("first_seen got %0b want %0b at index %0d",
						pix_out.first_seen, want.first_seen, want.palette_index));
			end
		end
	end

	// hang detection: any transfer on either stream or the register port resets the count
	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
			|| (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("timeout: no transfer for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, expected_maps.size());
		$display("Mismatches found");
		$finish;
	end

	// stimulus
	initial begin
		pixel_cmd_t    it;
		mapped_pixel_t typed_res;
		int            n_eff;
		int            j;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_in.valid <= 1'b0;
		pix_in.command <= pcm_pkg::CMD_MAP;
		pix_in.red <= '0;
		pix_in.green <= '0;
		pix_in.blue <= '0;
		pix_in.entry_index <= '0;
		pix_in.frame_start <= 1'b0;
		size_model = pcm_pkg::PALETTE_SIZE_RESET;
		foreach (seen_model[i]) begin
			seen_model[i] = 1'b0;
			pal_loaded[i] = 1'b0;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// palette_size must come out of reset at its default
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= SIZE_REG_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== pcm_pkg::DATA_W'(pcm_pkg::PALETTE_SIZE_RESET))
			report_mismatch($sformatf("palette_size after reset reads %0d want %0d",
				prdata, pcm_pkg::PALETTE_SIZE_RESET));
		psel <= 1'b0;
		penable <= 1'b0;

		// directed sequence
		foreach (dir_table[row]) begin
			if (dir_table[row].kind == ROW_SIZE) begin
				set_palette_size(dir_table[row].size_val);
			end else begin
				it.command = dir_table[row].command;
				it.color = '{dir_table[row].red, dir_table[row].green, dir_table[row].blue};
				it.entry_index = dir_table[row].entry_index;
				it.frame_start = dir_table[row].frame_start;
				typed_res.color = '{dir_table[row].exp_red, dir_table[row].exp_green,
					dir_table[row].exp_blue};
				typed_res.palette_index = dir_table[row].exp_index;
				typed_res.first_seen = dir_table[row].exp_first;
				send_cmd(it, dir_table[row].checked, typed_res);
			end
		end

		// random phases, one palette_size each
		for (int p = 0; p < NUM_PHASES; p++) begin
			// some phases run at full rate on both sides; the last one always does
			src_idle_on = (p != NUM_PHASES - 1) && (p % 3 != 2);
			sink_idle_on = src_idle_on;
			set_palette_size(pcm_pkg::SIZE_W'(PHASE_SIZES[p]));
			n_eff = search_len(size_model);

			// every searched slot gets a color before the first map that can reach it
			for (int e = 0; e < n_eff; e++) begin
				if (!pal_loaded[e]) begin
					it.command = pcm_pkg::CMD_WRITE;
					it.color = 24'($urandom);
					it.entry_index = pcm_pkg::IDX_W'(e);
					it.frame_start = 1'($urandom_range(0, 1));
					send_cmd(it, 1'b0, '0);
				end
			end

			// back up the whole chain while pixels keep coming
			if (p == LONG_HOLD_PHASE)
				hold_request = LONG_HOLD_CYCLES;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// let the block run completely dry before going on
				if (p == PAUSE_PHASE && k == PHASE_ITEMS / 2) begin
					pix_in.valid <= 1'b0;
					do
						@(posedge clk);
					while (expected_maps.size() != 0);
				end
				it.frame_start = ($urandom_range(0, 19) == 0);
				if ($urandom_range(0, 4) == 0) begin
					// reload: any slot, searched or not
					it.command = pcm_pkg::CMD_WRITE;
					it.color = 24'($urandom);
					it.entry_index = pcm_pkg::IDX_W'($urandom_range(0,
						pcm_pkg::PALETTE_DEPTH - 1));
				end else begin
					it.command = pcm_pkg::CMD_MAP;
					// entry_index is a don't-care on maps, keep it moving
					it.entry_index = pcm_pkg::IDX_W'($urandom);
					if ($urandom_range(0, 1) == 0) begin
						it.color = 24'($urandom);
					end else begin
						// close to a palette color so hits spread over the searched indexes
						j = $urandom_range(0, n_eff - 1);
						it.color.red = nudge(pal_model[j].red);
						it.color.green = nudge(pal_model[j].green);
						it.color.blue = nudge(pal_model[j].blue);
					end
				end
				send_cmd(it, 1'b0, '0);
			end
		end

		pix_in.valid <= 1'b0;
		while (expected_maps.size() != 0)
			@(posedge clk);
		// catch any stray result after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("checked %0d nearest-color results and sent %0d palette loads over %0d sizes",
			maps_checked, loads_sent, size_settings);
		$display("sizes 0, 1, 4, 64 and 127 used, with a %0d-cycle output hold and a full drain pause",
			LONG_HOLD_CYCLES);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
